[sv/crs_pkg.sv]
// shared types and constants for the catmull-rom spline evaluator
// no dependencies; used by every module of the block

package crs_pkg;

  localparam int COORD_W = 24;
  localparam int AP_W    = 4;
  localparam int IDX_W   = 3;
  localparam int T_W     = 17;
  localparam int FRAC_W  = 16;
  localparam int ROW_W   = 3 * COORD_W;

  localparam int ONE_Q16    = 65536;
  localparam int MIN_POINTS = 4;
  localparam int SEG_SPAN   = 3;
  localparam int TAPS       = 4;

  // horner accumulator width, holds 23 * 2^39 with sign
  localparam int H_W = 46;

  localparam logic [AP_W-1:0] ACTIVE_POINTS_RST = 4'd6;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } opcode_t;

  // store write request, row packed as {x, y, z}
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [ROW_W-1:0] row;
  } store_wr_t;

endpackage

[sv/catmull_rom_spline_eval.sv]
// top level of the uniform catmull-rom spline evaluator
// depends on crs_pkg, crs_locate, crs_store and crs_axis
//
//   channel  direction  handshake            payload
//   in_      request    in_valid/in_ready    opcode, point_index, write_x/y/z, param_t
//   out_     result     out_valid/out_ready  pos_x, pos_y, pos_z
//   cfg_     write      cfg_wr_en            cfg_wr_data (active_points)
//
// one request per cycle sustained while the output is not stalled
// seven register stages: input, point read, coefficients, three horner steps, output
// the whole pipe moves on one enable; a stalled output freezes every stage in place
// a write request updates the store as it leaves the input stage, so later
// evaluates always see it; writes give no result
// rst_n is synchronous; it clears the valid bits and sets active_points to 6,
// the point store is not cleared

module catmull_rom_spline_eval #(
  parameter int MAX_POINTS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [0:0]                    in_opcode,
  input  logic [crs_pkg::IDX_W-1:0]     in_point_index,
  input  logic signed [crs_pkg::COORD_W-1:0] in_write_x,
  input  logic signed [crs_pkg::COORD_W-1:0] in_write_y,
  input  logic signed [crs_pkg::COORD_W-1:0] in_write_z,
  input  logic [crs_pkg::T_W-1:0]       in_param_t,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [crs_pkg::COORD_W-1:0] out_pos_x,
  output logic signed [crs_pkg::COORD_W-1:0] out_pos_y,
  output logic signed [crs_pkg::COORD_W-1:0] out_pos_z,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [crs_pkg::AP_W-1:0]      cfg_wr_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = crs_pkg::COORD_W;

  // pipe enable
  logic adv;

  // config
  logic [crs_pkg::AP_W-1:0] active_points_r;

  // input stage
  logic                      v1_r;
  crs_pkg::opcode_t          op1_r;
  logic [crs_pkg::IDX_W-1:0] idx1_r;
  crs_pkg::coord_t           wx1_r, wy1_r, wz1_r;
  logic [crs_pkg::T_W-1:0]   t1_r;

  // locate and store
  logic [crs_pkg::TAPS-1:0][AW-1:0]            rd_addr;
  logic [crs_pkg::T_W-1:0]                     loc_u;
  crs_pkg::store_wr_t                          store_wr;
  logic [crs_pkg::TAPS-1:0][crs_pkg::ROW_W-1:0] rd_row_r;
  logic [crs_pkg::T_W-1:0]                     u2_r;

  // evaluate valid bits per stage
  logic e2_r, e3_r, e4_r, e5_r, e6_r;
  logic out_valid_r;

  crs_pkg::coord_t res_x, res_y, res_z;
  crs_pkg::coord_t out_x_r, out_y_r, out_z_r;

  // the output register frees up when empty or being drained
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;
  assign out_pos_x = out_x_r;
  assign out_pos_y = out_y_r;
  assign out_pos_z = out_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_points_r <= crs_pkg::ACTIVE_POINTS_RST;
    end else if (cfg_wr_en) begin
      active_points_r <= cfg_wr_data;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      e2_r        <= 1'b0;
      e3_r        <= 1'b0;
      e4_r        <= 1'b0;
      e5_r        <= 1'b0;
      e6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      e2_r        <= v1_r && (op1_r == crs_pkg::OP_EVAL);
      e3_r        <= e2_r;
      e4_r        <= e3_r;
      e5_r        <= e4_r;
      e6_r        <= e5_r;
      out_valid_r <= e6_r;
    end
  end

  // input payload
  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r  <= crs_pkg::opcode_t'(in_opcode);
      idx1_r <= in_point_index;
      wx1_r  <= in_write_x;
      wy1_r  <= in_write_y;
      wz1_r  <= in_write_z;
      t1_r   <= in_param_t;
    end
  end

  crs_locate #(
    .MAX_POINTS (MAX_POINTS)
  ) u_locate (
    .active_points (active_points_r),
    .param_t       (t1_r),
    .rd_addr       (rd_addr),
    .local_u       (loc_u)
  );

  // write happens in the same stage the evaluates read, keeping request order
  always_comb begin
    store_wr.en  = adv && v1_r && (op1_r == crs_pkg::OP_WRITE);
    store_wr.idx = idx1_r;
    store_wr.row = {wx1_r, wy1_r, wz1_r};
  end

  crs_store #(
    .MAX_POINTS (MAX_POINTS)
  ) u_store (
    .clk      (clk),
    .rd_en    (adv),
    .rd_addr  (rd_addr),
    .wr       (store_wr),
    .rd_row_r (rd_row_r)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      u2_r <= loc_u;
    end
  end

  // one lane per coordinate, row layout {x, y, z}
  crs_axis u_axis_x (
    .clk (clk),
    .en  (adv),
    .p0  (rd_row_r[0][3*CW-1:2*CW]),
    .p1  (rd_row_r[1][3*CW-1:2*CW]),
    .p2  (rd_row_r[2][3*CW-1:2*CW]),
    .p3  (rd_row_r[3][3*CW-1:2*CW]),
    .u   (u2_r),
    .pos (res_x)
  );

  crs_axis u_axis_y (
    .clk (clk),
    .en  (adv),
    .p0  (rd_row_r[0][2*CW-1:CW]),
    .p1  (rd_row_r[1][2*CW-1:CW]),
    .p2  (rd_row_r[2][2*CW-1:CW]),
    .p3  (rd_row_r[3][2*CW-1:CW]),
    .u   (u2_r),
    .pos (res_y)
  );

  crs_axis u_axis_z (
    .clk (clk),
    .en  (adv),
    .p0  (rd_row_r[0][CW-1:0]),
    .p1  (rd_row_r[1][CW-1:0]),
    .p2  (rd_row_r[2][CW-1:0]),
    .p3  (rd_row_r[3][CW-1:0]),
    .u   (u2_r),
    .pos (res_z)
  );

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r <= res_x;
      out_y_r <= res_y;
      out_z_r <= res_z;
    end
  end

`ifndef SYNTHESIS
  // an evaluate leaving the input stage shows up in the read stage
  a_eval_enters: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v1_r && (op1_r == crs_pkg::OP_EVAL) |=> e2_r)
    else $error("evaluate request lost at store read");

  // a write never turns into a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v1_r && (op1_r == crs_pkg::OP_WRITE) |=> !e2_r)
    else $error("write request produced a result slot");

  // a stall freezes the inner valid bits
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({e2_r, e3_r, e4_r, e5_r, e6_r}))
    else $error("pipeline moved during stall");

  // the local parameter never passes one
  a_u_range: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && (op1_r == crs_pkg::OP_EVAL) |-> loc_u <= crs_pkg::T_W'(crs_pkg::ONE_Q16))
    else $error("local parameter above one");
`endif

endmodule

[sv/crs_locate.sv]
// segment locator: clamps point count and t, forms s = t*(n-3), seg and local u
// depends on crs_pkg

module crs_locate #(
  parameter int MAX_POINTS = 8
) (
  input  logic [crs_pkg::AP_W-1:0]                        active_points,
  input  logic [crs_pkg::T_W-1:0]                         param_t,
  output logic [crs_pkg::TAPS-1:0][$clog2(MAX_POINTS)-1:0] rd_addr,
  output logic [crs_pkg::T_W-1:0]                         local_u
);

  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int CW = (NW > crs_pkg::AP_W) ? NW : crs_pkg::AP_W;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int SW = crs_pkg::T_W + CW;

  logic [CW-1:0]                 ap_ext;
  logic [CW-1:0]                 n;
  logic [CW-1:0]                 seg_max;
  logic [CW-1:0]                 seg;
  logic [crs_pkg::T_W-1:0]       t_sat;
  logic [SW-1:0]                 s;
  logic [SW-1:0]                 rem;
  logic [SW-crs_pkg::FRAC_W-1:0] seg_raw;

  always_comb begin
    ap_ext = CW'(active_points);
    if (ap_ext < CW'(crs_pkg::MIN_POINTS)) begin
      n = CW'(crs_pkg::MIN_POINTS);
    end else if (ap_ext > CW'(MAX_POINTS)) begin
      n = CW'(MAX_POINTS);
    end else begin
      n = ap_ext;
    end
    t_sat   = (param_t > crs_pkg::T_W'(crs_pkg::ONE_Q16)) ?
              crs_pkg::T_W'(crs_pkg::ONE_Q16) : param_t;
    s       = SW'(t_sat) * SW'(n - CW'(crs_pkg::SEG_SPAN));
    seg_raw = s[SW-1:crs_pkg::FRAC_W];
    seg_max = n - CW'(crs_pkg::MIN_POINTS);
    // t = 1.0 lands on the last segment with u = 1.0
    seg     = (seg_raw > (CW+1)'(seg_max)) ? seg_max : seg_raw[CW-1:0];
    rem     = s - (SW'(seg) << crs_pkg::FRAC_W);
    local_u = rem[crs_pkg::T_W-1:0];
  end

  for (genvar k = 0; k < crs_pkg::TAPS; k++) begin : g_addr
    assign rd_addr[k] = AW'(seg + CW'(k));
  end

endmodule

[sv/crs_store.sv]
// control point store: one copy per tap so each copy sees one read address
// depends on crs_pkg

module crs_store #(
  parameter int MAX_POINTS = 8
) (
  input  logic                                            clk,
  input  logic                                            rd_en,
  input  logic [crs_pkg::TAPS-1:0][$clog2(MAX_POINTS)-1:0] rd_addr,
  input  crs_pkg::store_wr_t                              wr,
  output logic [crs_pkg::TAPS-1:0][crs_pkg::ROW_W-1:0]    rd_row_r
);

  localparam int AW = $clog2(MAX_POINTS);

  logic wr_hit;

  // slots beyond the store are dropped
  assign wr_hit = wr.en && (int'(wr.idx) < MAX_POINTS);

  for (genvar k = 0; k < crs_pkg::TAPS; k++) begin : g_copy
    logic [crs_pkg::ROW_W-1:0] mem [MAX_POINTS];

    always_ff @(posedge clk) begin
      if (wr_hit) begin
        mem[AW'(wr.idx)] <= wr.row;
      end
    end

    always_ff @(posedge clk) begin
      if (rd_en) begin
        rd_row_r[k] <= mem[rd_addr[k]];
      end
    end
  end

endmodule

[sv/crs_axis.sv]
// one coordinate lane: blend coefficients, three horner steps, round and saturate
// depends on crs_pkg

module crs_axis (
  input  logic                    clk,
  input  logic                    en,
  input  crs_pkg::coord_t         p0,
  input  crs_pkg::coord_t         p1,
  input  crs_pkg::coord_t         p2,
  input  crs_pkg::coord_t         p3,
  input  logic [crs_pkg::T_W-1:0] u,
  output crs_pkg::coord_t         pos
);

  localparam int HW  = crs_pkg::H_W;
  localparam int HIW = HW - crs_pkg::FRAC_W;
  localparam int RW  = HW + 1 - (crs_pkg::FRAC_W + 1);
  localparam int LW  = crs_pkg::FRAC_W + crs_pkg::T_W;

  // coefficient stage
  logic signed [24:0] a_nxt, b_nxt;
  logic signed [27:0] c_nxt;
  logic signed [26:0] d_nxt;
  logic signed [27:0] e0, e1, e2, e3;
  logic signed [26:0] f0, f1, f2, f3;
  logic signed [24:0] a_r, b_r, a4_r, b4_r, a5_r;
  logic signed [27:0] c_r;
  logic signed [26:0] d_r;
  logic [crs_pkg::T_W-1:0] u3_r, u4_r, u5_r;

  // horner stages
  logic signed [crs_pkg::T_W:0] us3, us4, us5;
  logic signed [44:0]           prod1;
  logic signed [HIW-1:0]        hi1, hi2;
  logic [crs_pkg::FRAC_W-1:0]   lo1, lo2;
  logic signed [HIW+crs_pkg::T_W:0] prod_hi1, prod_hi2;
  logic [LW-1:0]                prod_lo1, prod_lo2;
  logic signed [HW-1:0]         h1_nxt, h2_nxt, h3_nxt;
  logic signed [HW-1:0]         h1_r, h2_r, h3_r;

  // rounding
  logic signed [HW:0]   rsum;
  logic signed [RW-1:0] rsh;

  always_comb begin
    e0    = 28'(p0);
    e1    = 28'(p1);
    e2    = 28'(p2);
    e3    = 28'(p3);
    f0    = 27'(p0);
    f1    = 27'(p1);
    f2    = 27'(p2);
    f3    = 27'(p3);
    a_nxt = 25'(p1) <<< 1;
    b_nxt = 25'(p2) - 25'(p0);
    c_nxt = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    d_nxt = (f1 <<< 1) + f1 - f0 - (f2 <<< 1) - f2 + f3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      c_r  <= c_nxt;
      d_r  <= d_nxt;
      u3_r <= u;
    end
  end

  // h1 = d*u + c*2^16
  always_comb begin
    us3    = $signed({1'b0, u3_r});
    prod1  = d_r * us3;
    h1_nxt = HW'(prod1) + (HW'(c_r) <<< crs_pkg::FRAC_W);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1_r <= h1_nxt;
      a4_r <= a_r;
      b4_r <= b_r;
      u4_r <= u3_r;
    end
  end

  // h2 = floor(h1*u / 2^16) + b*2^16, split into high and low partial products
  always_comb begin
    us4      = $signed({1'b0, u4_r});
    hi1      = h1_r[HW-1:crs_pkg::FRAC_W];
    lo1      = h1_r[crs_pkg::FRAC_W-1:0];
    prod_hi1 = hi1 * us4;
    prod_lo1 = lo1 * u4_r;
    h2_nxt   = HW'(prod_hi1) + HW'(prod_lo1[LW-1:crs_pkg::FRAC_W])
             + (HW'(b4_r) <<< crs_pkg::FRAC_W);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h2_r <= h2_nxt;
      a5_r <= a4_r;
      u5_r <= u4_r;
    end
  end

  always_comb begin
    us5      = $signed({1'b0, u5_r});
    hi2      = h2_r[HW-1:crs_pkg::FRAC_W];
    lo2      = h2_r[crs_pkg::FRAC_W-1:0];
    prod_hi2 = hi2 * us5;
    prod_lo2 = lo2 * u5_r;
    h3_nxt   = HW'(prod_hi2) + HW'(prod_lo2[LW-1:crs_pkg::FRAC_W])
             + (HW'(a5_r) <<< crs_pkg::FRAC_W);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h3_r <= h3_nxt;
    end
  end

  // halve with round half up, then clamp to q11.12
  always_comb begin
    rsum = {h3_r[HW-1], h3_r} + (HW+1)'(crs_pkg::ONE_Q16);
    rsh  = RW'(rsum >>> (crs_pkg::FRAC_W + 1));
    if ((&rsh[RW-1:crs_pkg::COORD_W-1]) || !(|rsh[RW-1:crs_pkg::COORD_W-1])) begin
      pos = rsh[crs_pkg::COORD_W-1:0];
    end else if (rsh[RW-1]) begin
      pos = {1'b1, {(crs_pkg::COORD_W-1){1'b0}}};
    end else begin
      pos = {1'b0, {(crs_pkg::COORD_W-1){1'b1}}};
    end
  end

endmodule
